@@ rtl/crc8fc_pkg.sv @@
`default_nettype none

package crc8fc_pkg;

   localparam logic [7:0] CRC_POLY          = 8'h97;
   localparam int         FRAME_BYTES_W     = 4;
   localparam int         LEN_W             = 5;
   localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RESET = 4'd3;
   localparam logic [LEN_W-1:0]         FRAME_BYTES_MIN   = 5'd2;

   // first member lands in the highest bits, so crc_ok sits at bit 0
   typedef struct packed {
      logic       error_seen;
      logic [7:0] calculated_crc;
      logic [7:0] received_crc;
      logic       crc_ok;
   } result_type;

   typedef struct packed {
      logic       vld;
      logic [7:0] rx_byte;
   } item_type;

   // one byte through the CRC, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/crc8fc_in_reg.sv @@
`default_nettype none

module crc8fc_in_reg
   import crc8fc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_vld,
   output      logic       in_rdy,
   input  wire logic [7:0] in_byte,
   input  wire logic       advance,
   output      item_type   item
);

   logic       vld_ff, vld_in;
   logic [7:0] byte_ff;

   // take a new transaction when empty or when the held byte moves on
   assign in_rdy = !vld_ff || advance;

   always_comb begin
      vld_in = vld_ff;
      if (in_rdy) begin
         vld_in = in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && in_vld) begin
         byte_ff <= in_byte;
      end
   end

   assign item.vld     = vld_ff;
   assign item.rx_byte = byte_ff;

endmodule

`default_nettype wire

@@ rtl/crc8fc_check.sv @@
`default_nettype none

module crc8fc_check
   import crc8fc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 8
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cfg_wen,
   input  wire logic [FRAME_BYTES_W-1:0] cfg_frame_bytes,
   input  wire item_type                 item,
   output      logic                     advance,
   output      logic                     out_vld,
   input  wire logic                     out_rdy,
   output      result_type               out_res
);

   localparam int IDX_W = (MAX_FRAME_BYTES > 2) ? $clog2(MAX_FRAME_BYTES) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);

   logic [FRAME_BYTES_W-1:0] frame_bytes_ff;
   logic [7:0]               crc_ff, crc_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     err_ff, err_in;
   logic                     out_vld_ff, out_vld_in;
   result_type               res_ff, res_in;

   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] pos;
   logic             last;
   logic             out_free;

   always_comb begin
      len = {1'b0, frame_bytes_ff};
      if (len < FRAME_BYTES_MIN) begin
         len = FRAME_BYTES_MIN;
      end else if (len > LEN_MAX) begin
         len = LEN_MAX;
      end
   end

   assign pos      = LEN_W'(idx_ff) + LEN_W'(1);
   assign last     = pos >= len;
   assign out_free = !out_vld_ff || out_rdy;
   assign advance  = item.vld && out_free;

   always_comb begin
      crc_in     = crc_ff;
      idx_in     = idx_ff;
      err_in     = err_ff;
      out_vld_in = out_vld_ff && !out_rdy;
      res_in     = res_ff;
      if (advance) begin
         if (last) begin
            res_in.received_crc   = ~item.rx_byte;
            res_in.calculated_crc = crc_ff;
            res_in.crc_ok         = (~item.rx_byte == crc_ff);
            res_in.error_seen     = err_ff || (~item.rx_byte != crc_ff);
            err_in     = res_in.error_seen;
            crc_in     = '0;
            idx_in     = '0;
            out_vld_in = 1'b1;
         end else begin
            crc_in = crc8_update(crc_ff, item.rx_byte);
            idx_in = IDX_W'(pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bytes_ff <= FRAME_BYTES_RESET;
         crc_ff         <= '0;
         idx_ff         <= '0;
         err_ff         <= 1'b0;
         out_vld_ff     <= 1'b0;
      end else begin
         if (cfg_wen) begin
            frame_bytes_ff <= cfg_frame_bytes;
         end
         crc_ff     <= crc_in;
         idx_ff     <= idx_in;
         err_ff     <= err_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_vld = out_vld_ff;
   assign out_res = res_ff;

endmodule

`default_nettype wire

@@ rtl/crc8_frame_checker_unit.sv @@
// CRC-8 frame checker (polynomial 0x97, MSB first, zero initial value).
// req_*: one received byte per transaction, in arrival order. A frame has
//   csr_wr_data bytes (clamped to 2..MAX_FRAME_BYTES); the last one is the
//   inverted CRC of the bytes before it.
// rsp_*: one transaction per frame, on its last byte: pass flag, inverted
//   received CRC, calculated CRC and a sticky error flag.
// csr_*: frame length register, written when csr_wr_en is high; write it
//   only while no byte is held inside the block.
// Path: a last byte passes the input register, then registers rsp_tvalid.
// Throughput: one byte per cycle unless a result stalls; the CRC of a byte
//   is a single pass of eight xor/shift steps from input register to state.
// Reset: clears the CRC, the byte position, the error flag and both
//   pipeline valids; the frame length returns to 3.
// Stall: while rsp_tready is low a result holds and one more byte waits in
//   the input register; then req_tready drops.
`default_nettype none

module crc8_frame_checker_unit
   import crc8fc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 8
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,    // [0] crc_ok, [8:1] received_crc,
                                          // [16:9] calculated_crc, [17] error_seen
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data   // frame_bytes
);

   item_type   item;
   logic       advance;
   result_type res;

   crc8fc_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_tvalid),
      .in_rdy  (req_tready),
      .in_byte (req_tdata),
      .advance (advance),
      .item    (item)
   );

   crc8fc_check #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .cfg_wen         (csr_wr_en),
      .cfg_frame_bytes (csr_wr_data),
      .item            (item),
      .advance         (advance),
      .out_vld         (rsp_tvalid),
      .out_rdy         (rsp_tready),
      .out_res         (res)
   );

   assign rsp_tdata = {6'd0, res};

endmodule

`default_nettype wire

@@ tb/crc8_frame_checker_unit_test.sv @@
module crc8_frame_checker_unit_test;
   import crc8fc_pkg::*;

   localparam int MAX_LEN         = 8;
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_BYTES    = 1025;
   localparam int MAX_PRINTS      = 30;

   typedef enum logic [1:0] {
      STEP_BYTE,
      STEP_CFG,
      STEP_DRAIN,
      STEP_PHASE
   } step_kind_type;

   typedef enum logic [1:0] {
      PHASE_LIGHT_TX,
      PHASE_HEAVY_TX,
      PHASE_NO_IDLE
   } idle_phase_type;

   typedef struct {
      step_kind_type kind;
      logic [7:0]    value;
   } plan_step_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [3:0]  csr_wr_data = 4'd0;

   plan_step_type plan_q[$];
   result_type    verdict_q[$];

   // frame checker state as the block should hold it
   logic [3:0]  frame_len;
   logic [7:0]  crc_acc;
   int          byte_pos;
   logic        err_flag;

   int          tx_gap_pct    = 8;
   int          rx_stall_pct  = 45;
   int          quiet_cycles  = 0;
   int          idle_cycles   = 0;
   int          fail_count    = 0;
   int          frame_checks  = 0;
   int          bytes_sent    = 0;
   int          len_writes    = 0;
   int          bytes_planned = 0;
   int          plan_len      = 3;

   crc8_frame_checker_unit #(.MAX_FRAME_BYTES(MAX_LEN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bit-serial form: feed each data bit into the top of the register
   function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[7] ^ d[k];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic int effective_len(input logic [3:0] v);
      if (v < FRAME_BYTES_MIN) begin
         return FRAME_BYTES_MIN;
      end
      if (v > MAX_LEN) begin
         return MAX_LEN;
      end
      return v;
   endfunction

   function void frame_model_byte(input logic [7:0] d);
      result_type r;
      if (byte_pos + 1 >= effective_len(frame_len)) begin
         r.crc_ok         = (~d == crc_acc);
         r.received_crc   = ~d;
         r.calculated_crc = crc_acc;
         if (!r.crc_ok) begin
            err_flag = 1'b1;
         end
         r.error_seen = err_flag;
         verdict_q.push_back(r);
         crc_acc  = 8'h00;
         byte_pos = 0;
      end else begin
         crc_acc  = crc8_next(crc_acc, d);
         byte_pos = byte_pos + 1;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < MAX_PRINTS) begin
         $display("mismatch on frame %0d: %s got 0x%0h want 0x%0h",
                  frame_checks, what, got, want);
      end
      fail_count++;
   endtask

   function void push_step(input step_kind_type k, input logic [7:0] v);
      plan_q.push_back('{k, v});
      if (k == STEP_BYTE) begin
         bytes_planned++;
      end
   endfunction

   function void push_len(input logic [3:0] v);
      push_step(STEP_CFG, {4'd0, v});
      plan_len = effective_len(v);
   endfunction

   // fill below zero means random payload bytes
   function void push_frame(input int len, input bit corrupt, input int fill);
      logic [7:0] acc;
      logic [7:0] d;
      acc = 8'h00;
      for (int i = 0; i < len - 1; i++) begin
         d   = (fill < 0) ? 8'($urandom) : 8'(fill);
         acc = crc8_next(acc, d);
         push_step(STEP_BYTE, d);
      end
      d = ~acc;
      if (corrupt) begin
         d = d ^ 8'($urandom_range(1, 255));
      end
      push_step(STEP_BYTE, d);
   endfunction

   function void push_noise(input int len);
      for (int i = 0; i < len; i++) begin
         push_step(STEP_BYTE, 8'($urandom));
      end
   endfunction

   always @(posedge clock) begin : driver
      logic          next_valid;
      logic          next_wr;
      plan_step_type step;
      next_valid = req_tvalid;
      next_wr    = 1'b0;
      if (reset) begin
         next_valid   = 1'b0;
         quiet_cycles = 0;
         frame_len    = FRAME_BYTES_RESET;
         crc_acc      = 8'h00;
         byte_pos     = 0;
         err_flag     = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_model_byte(req_tdata);
            bytes_sent++;
            next_valid = 1'b0;
         end
         quiet_cycles = req_tvalid ? 0 : quiet_cycles + 1;
         if (!next_valid && plan_q.size() > 0) begin
            step = plan_q[0];
            case (step.kind)
               STEP_BYTE: begin
                  if ($urandom_range(99) >= tx_gap_pct) begin
                     next_valid = 1'b1;
                     req_tdata <= step.value;
                     void'(plan_q.pop_front());
                  end
               end
               STEP_CFG: begin
                  // write only once all results are out and the input stage has drained
                  if (verdict_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                     next_wr = 1'b1;
                     csr_wr_data <= step.value[3:0];
                     frame_len = step.value[3:0];
                     len_writes++;
                     void'(plan_q.pop_front());
                  end
               end
               STEP_DRAIN: begin
                  if (verdict_q.size() == 0) begin
                     void'(plan_q.pop_front());
                  end
               end
               STEP_PHASE: begin
                  case (idle_phase_type'(step.value[1:0]))
                     PHASE_LIGHT_TX: begin
                        tx_gap_pct   = 8;
                        rx_stall_pct = 45;
                     end
                     PHASE_HEAVY_TX: begin
                        tx_gap_pct   = 45;
                        rx_stall_pct = 8;
                     end
                     default: begin
                        tx_gap_pct   = 0;
                        rx_stall_pct = 0;
                     end
                  endcase
                  void'(plan_q.pop_front());
               end
               default: begin
                  void'(plan_q.pop_front());
               end
            endcase
         end
      end
      req_tvalid <= next_valid;
      csr_wr_en  <= next_wr;
   end

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[17:0]);
            if (rsp_tdata[23:18] != '0) begin
               report_mismatch("pad bits", rsp_tdata[23:18], 0);
            end
            if (verdict_q.size() == 0) begin
               report_mismatch("result with none pending", rsp_tdata, 0);
            end else begin
               want = verdict_q.pop_front();
               if (got.crc_ok != want.crc_ok) begin
                  report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
               end
               if (got.received_crc != want.received_crc) begin
                  report_mismatch("received_crc", got.received_crc, want.received_crc);
               end
               if (got.calculated_crc != want.calculated_crc) begin
                  report_mismatch("calculated_crc", got.calculated_crc, want.calculated_crc);
               end
               if (got.error_seen != want.error_seen) begin
                  report_mismatch("error_seen", got.error_seen, want.error_seen);
               end
               frame_checks++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int r;
      int target;

      // default length of three: all-zero and all-one payloads, then a first failure
      push_frame(plan_len, 1'b0, 8'h00);
      push_frame(plan_len, 1'b0, 8'hFF);
      push_frame(plan_len, 1'b1, -1);
      push_len(4'd2);
      push_frame(plan_len, 1'b0, 8'hA5);
      // below the minimum saturates to two
      push_len(4'd0);
      push_frame(plan_len, 1'b1, -1);
      // above the maximum saturates to the longest frame
      push_len(4'd15);
      push_frame(plan_len, 1'b0, -1);
      // shorten the frame mid-way: the next byte closes it
      push_noise(3);
      push_len(4'd2);
      push_noise(1);
      push_step(STEP_DRAIN, 8'h00);

      for (int ph = 0; ph < 3; ph++) begin
         push_step(STEP_PHASE, 8'(ph));
         target = 25 + (RANDOM_BYTES * (ph + 1)) / 3;
         while (bytes_planned < target) begin
            if ($urandom_range(9) == 0) begin
               push_len(4'($urandom_range(15)));
            end
            r = $urandom_range(99);
            if (r < 85) begin
               push_frame(plan_len, 1'b0, -1);
            end else if (r < 95) begin
               push_frame(plan_len, 1'b1, -1);
            end else begin
               push_noise(plan_len);
            end
            if ($urandom_range(49) == 0) begin
               push_step(STEP_DRAIN, 8'h00);
            end
         end
         push_step(STEP_DRAIN, 8'h00);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!(plan_q.size() == 0 && !req_tvalid && verdict_q.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results outstanding",
                  idle_cycles, verdict_q.size());
         $display("simulation failed");
      end else begin
         repeat (8) @(posedge clock);
         $display("checked %0d frames from %0d bytes across %0d length writes",
                  frame_checks, bytes_sent, len_writes);
         $display("idle mixes: light sender, heavy sender, none; sticky error raised: %0b",
                  err_flag);
         if (fail_count == 0) begin
            $display("simulation ok");
         end else begin
            $display("simulation failed");
         end
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/crc8fc_pkg.sv
rtl/crc8fc_in_reg.sv
rtl/crc8fc_check.sv
rtl/crc8_frame_checker_unit.sv
tb/crc8_frame_checker_unit_test.sv
